### sv/dnle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dnle_pkg
// Shared types, codes and helpers for the DNS name label encoder.
// ----------------------------------------------------------------------------
package dnle_pkg;

  localparam int BUFFER_BYTES_DEF = 128;
  localparam logic [7:0] DOT_CHAR = 8'h2E;
  localparam int ADDR_W = 7;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [7:0]        write_byte;
    status_t           status;
    logic              last;
  } result_t;

  // Letters, digits and hyphen may stand in a label.
  function automatic logic is_label_char(input logic [7:0] c);
    logic ok;
    ok = (c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2D});
    return ok;
  endfunction

endpackage
`default_nettype wire

### sv/dns_name_label_encoder_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit
// Turns a dotted domain name, one character per item, into byte writes of
// the DNS wire form: length-prefixed labels and a zero terminator.
// ----------------------------------------------------------------------------
// A user feeds one name character per item (in_kind = 0) and closes the name
// with an end item (in_kind = 1). Each accepted character item is decoded in
// the cycle it is taken and its result, if any, lands in a four-entry result
// queue the same cycle, so one item per cycle is taken while the queue has
// room for two results; out_valid rises the cycle after. A label character
// writes itself at position + 1, a dot back-fills the finished label's length
// at its start, and an end item pushes two results (last label length, then
// the zero terminator), so an end item needs two free queue slots. Errors (empty
// label, invalid character) give one result with last set, then items are
// dropped until the end item. Characters beyond the buffer limit are ignored
// so the terminator always fits. in_stall is taken from the queue fill count
// alone, so an item is still accepted while a result waits on out_stall.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit
  import dnle_pkg::*;
#(
  parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_kind,
  input  wire logic [7:0]          in_char_code,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [ADDR_W-1:0]        out_write_address,
  output logic [7:0]               out_write_byte,
  output logic [1:0]               out_status,
  output logic                     out_last
);

  // Position, label length and label start all stay below BUFFER_BYTES.
  localparam int PW    = $clog2(BUFFER_BYTES);
  localparam int AW    = (PW > ADDR_W) ? PW : ADDR_W;
  localparam int DEPTH = 4;
  localparam int QPW   = $clog2(DEPTH);
  localparam int QCW   = QPW + 1;

  // name state
  logic [PW-1:0] position_r, position_nxt;
  logic [PW-1:0] label_length_r, label_length_nxt;
  logic [PW-1:0] label_start_r, label_start_nxt;
  logic          failed_r, failed_nxt;

  // result queue
  result_t       queue_r [DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  logic          in_fire;
  logic          out_fire;
  logic [1:0]    push_cnt;
  result_t       res0, res1;

  logic          full_limit;
  logic [AW-1:0] pos_inc_ext;
  logic [AW-1:0] start_ext;
  logic [PW-1:0] pos_inc;

  // Hold off input unless two result slots are free.
  assign in_stall  = (count_r > QCW'(DEPTH - 2));
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && !out_stall;

  assign pos_inc     = position_r + PW'(1);
  assign pos_inc_ext = AW'(pos_inc);
  assign start_ext   = AW'(label_start_r);
  assign full_limit  = ({1'b0, position_r} + (PW+1)'(2)) >= (PW+1)'(BUFFER_BYTES);

  // Decode one item: results and next name state.
  always_comb begin
    position_nxt     = position_r;
    label_length_nxt = label_length_r;
    label_start_nxt  = label_start_r;
    failed_nxt       = failed_r;
    push_cnt         = 2'd0;
    res0             = '{write_address: '0, write_byte: '0, status: STATUS_OK, last: 1'b0};
    res1             = '{write_address: '0, write_byte: '0, status: STATUS_OK, last: 1'b0};
    if (in_fire) begin
      if (in_kind) begin
        if (!failed_r) begin
          // Back-fill the last label's length, then terminate.
          push_cnt           = 2'd2;
          res0.write_address = start_ext[ADDR_W-1:0];
          res0.write_byte    = 8'(label_length_r);
          res1.write_address = pos_inc_ext[ADDR_W-1:0];
          res1.last          = 1'b1;
        end
        position_nxt     = '0;
        label_length_nxt = '0;
        label_start_nxt  = '0;
        failed_nxt       = 1'b0;
      end else if (!failed_r && !full_limit) begin
        if (is_label_char(in_char_code)) begin
          push_cnt           = 2'd1;
          res0.write_address = pos_inc_ext[ADDR_W-1:0];
          res0.write_byte    = in_char_code;
          label_length_nxt   = label_length_r + PW'(1);
          position_nxt       = pos_inc;
        end else if (in_char_code == DOT_CHAR) begin
          push_cnt = 2'd1;
          if (label_length_r == '0) begin
            failed_nxt  = 1'b1;
            res0.status = STATUS_EMPTY;
            res0.last   = 1'b1;
          end else begin
            res0.write_address = start_ext[ADDR_W-1:0];
            res0.write_byte    = 8'(label_length_r);
            label_start_nxt    = pos_inc;
            label_length_nxt   = '0;
            position_nxt       = pos_inc;
          end
        end else begin
          push_cnt    = 2'd1;
          failed_nxt  = 1'b1;
          res0.status = STATUS_INVALID;
          res0.last   = 1'b1;
        end
      end
    end
  end

  // Queue pointer and count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPW'(push_cnt);
    rd_ptr_nxt = rd_ptr_r + QPW'(out_fire);
    count_nxt  = count_r + QCW'(push_cnt) - QCW'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r     <= '0;
      label_length_r <= '0;
      label_start_r  <= '0;
      failed_r       <= 1'b0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      count_r        <= '0;
    end else begin
      position_r     <= position_nxt;
      label_length_r <= label_length_nxt;
      label_start_r  <= label_start_nxt;
      failed_r       <= failed_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      count_r        <= count_nxt;
    end
  end

  // Result payload store, no reset needed.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue_r[wr_ptr_r] <= res0;
    end
    if (push_cnt == 2'd2) begin
      queue_r[wr_ptr_r + QPW'(1)] <= res1;
    end
  end

  always_comb begin
    out_write_address = queue_r[rd_ptr_r].write_address;
    out_write_byte    = queue_r[rd_ptr_r].write_byte;
    out_status        = queue_r[rd_ptr_r].status;
    out_last          = queue_r[rd_ptr_r].last;
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(DEPTH))
    else $error("result queue count exceeds depth");

  a_label_track: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, label_start_r} + {1'b0, label_length_r}) == {1'b0, position_r})
    else $error("label start plus length does not match position");

  a_pos_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, position_r} + (PW+1)'(2)) <= (PW+1)'(BUFFER_BYTES))
    else $error("position ran past buffer limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_kind) |=> (position_r == '0 && label_length_r == '0 && !failed_r))
    else $error("end item did not clear name state");

  a_failed_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && failed_r) |=> (count_r <= $past(count_r)))
    else $error("result produced while failed");

endmodule
`default_nettype wire

### tb/sv/dns_name_label_encoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dns_name_label_encoder_unit_test
// Self-checking bench for the DNS name label encoder. Feeds dotted names
// one character per item, predicts every wire-form byte write and compares
// each result field by field. Random idle bursts hit both channels.
// ----------------------------------------------------------------------------
module dns_name_label_encoder_unit_test
  import dnle_pkg::*;
();

  localparam int BUF_BYTES    = BUFFER_BYTES_DEF;
  localparam int RANDOM_ITEMS = 1000;     // rough size of the random part
  localparam int QUIET_TAIL   = 150;      // last items run with no idling
  localparam int DRAIN_CYCLES = 20;       // settle time after the last write
  localparam int CYCLE_LIMIT  = 200000;   // watchdog bound, well above the slowest legal run
  localparam int MAX_PRINTED  = 40;       // cap on printed error lines

  localparam logic       KIND_CHAR = 1'b0;
  localparam logic       KIND_END  = 1'b1;
  localparam logic [7:0] HYPHEN    = 8'h2D;

  typedef struct packed {
    logic       kind;
    logic [7:0] code;
  } name_item_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic clk          = 1'b0;
  logic rst_n        = 1'b0;
  logic in_valid     = 1'b0;
  logic in_kind      = KIND_CHAR;
  logic [7:0] in_char_code = 8'h00;
  logic out_stall    = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [ADDR_W-1:0] out_write_address;
  logic [7:0]        out_write_byte;
  logic [1:0]        out_status;
  logic              out_last;

  always #5 clk = ~clk;

  dns_name_label_encoder_unit #(
    .BUFFER_BYTES(BUF_BYTES)
  ) u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_address(out_write_address),
    .out_write_byte   (out_write_byte),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  name_item_t pending_items[$];    // items still to be driven
  result_t    expected_writes[$];  // predicted writes, oldest first

  int total_items    = 0;
  int accepted_items = 0;
  int writes_checked = 0;
  int n_errors       = 0;
  int names_seen     = 0;
  int names_failed   = 0;
  int names_full     = 0;
  int cycle_count    = 0;

  // Encoder shadow state, advanced once per accepted item.
  int name_pos       = 0;   // name characters taken so far
  int label_len      = 0;   // characters in the open label
  int label_base     = 0;   // buffer slot of the open label's length byte
  bit name_failed    = 1'b0;
  bit name_hit_limit = 1'b0;

  task automatic flag_error(input string msg);
    if (n_errors < MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, msg);
    n_errors++;
  endtask

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  // Letters, digits and hyphen are the only characters a label may hold.
  function automatic bit is_host_char(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h30 && c <= 8'h39) || (c == HYPHEN);
  endfunction

  function automatic void push_write(input int addr, input int wbyte,
                                     input status_t st, input logic fin);
    result_t r;
    r.write_address = addr[ADDR_W-1:0];
    r.write_byte    = wbyte[7:0];
    r.status        = st;
    r.last          = fin;
    expected_writes = {expected_writes, r};
  endfunction

  // Work out the writes one accepted item causes and advance the shadow state.
  task automatic predict_label_writes(input logic kind, input logic [7:0] code);
    if (kind == KIND_END) begin
      names_seen++;
      if (name_failed) begin
        names_failed++;
      end else begin
        // Close the open label, then terminate the name right after it.
        push_write(label_base, label_len, STATUS_OK, 1'b0);
        push_write(name_pos + 1, 0, STATUS_OK, 1'b1);
      end
      if (name_hit_limit)
        names_full++;
      name_pos       = 0;
      label_len      = 0;
      label_base     = 0;
      name_failed    = 1'b0;
      name_hit_limit = 1'b0;
    end else if (!name_failed) begin
      if (name_pos + 2 >= BUF_BYTES) begin
        // Buffer full: drop the character so the terminator still fits.
        name_hit_limit = 1'b1;
      end else if (is_host_char(code)) begin
        push_write(name_pos + 1, int'(code), STATUS_OK, 1'b0);
        label_len++;
        name_pos++;
      end else if (code == DOT_CHAR) begin
        if (label_len == 0) begin
          name_failed = 1'b1;
          push_write(0, 0, STATUS_EMPTY, 1'b1);
        end else begin
          // Back-fill the finished label's length at its start.
          push_write(label_base, label_len, STATUS_OK, 1'b0);
          label_base += label_len + 1;
          label_len   = 0;
          name_pos++;
        end
      end else begin
        name_failed = 1'b1;
        push_write(0, 0, STATUS_INVALID, 1'b1);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building
  // --------------------------------------------------------------------------
  task automatic push_item(input logic kind, input logic [7:0] code);
    name_item_t it;
    it.kind = kind;
    it.code = code;
    pending_items = {pending_items, it};
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      push_item(KIND_CHAR, s[i]);
  endtask

  function automatic logic [7:0] rand_label_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 62);
    if (r < 26)      c = 8'h41 + 8'(r);
    else if (r < 52) c = 8'h61 + 8'(r - 26);
    else if (r < 62) c = 8'h30 + 8'(r - 52);
    else             c = HYPHEN;
    return c;
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    do
      c = 8'($urandom_range(0, 255));
    while (is_host_char(c) || c == DOT_CHAR);
    return c;
  endfunction

  // Mostly well-formed names with random labels; the rest is noise, names
  // with one corrupted character, and a few long names that fill the buffer.
  task automatic queue_random_name();
    int shape;
    int n_labels;
    int len;
    int k;
    logic [7:0] body[$];
    shape = $urandom_range(0, 99);
    if (shape < 12) begin
      // Noise: random kinds and bytes, may leave a name half done.
      repeat ($urandom_range(1, 8))
        push_item(($urandom_range(0, 3) == 0) ? KIND_END : KIND_CHAR,
                  8'($urandom_range(0, 255)));
      return;
    end
    if (shape < 14) begin
      // Long name: labels often longer than 63, may run past the buffer limit.
      len = $urandom_range(100, 140);
      for (k = 0; k < len; k++)
        body = {body, ((k > 0 && $urandom_range(0, 39) == 0) ? DOT_CHAR
                                                             : rand_label_char())};
    end else begin
      n_labels = $urandom_range(1, 4);
      for (k = 0; k < n_labels; k++) begin
        if (k > 0)
          body = {body, DOT_CHAR};
        len = $urandom_range(1, 10);
        repeat (len) body = {body, rand_label_char()};
      end
      if ($urandom_range(0, 7) == 0)
        body = {body, DOT_CHAR};
      if (shape >= 80) begin
        // Break the name: a stray dot or a character no label may hold.
        k = $urandom_range(0, body.size() - 1);
        body[k] = ($urandom_range(0, 1) == 0) ? DOT_CHAR : rand_bad_char();
      end
    end
    foreach (body[i])
      push_item(KIND_CHAR, body[i]);
    push_item(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Driver: present pending items, predict each one at acceptance.
  // A stalled item is held as is; gaps only start between items.
  // --------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_kind      <= KIND_CHAR;
      in_char_code <= 8'h00;
      send_gap      = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_label_writes(in_kind, in_char_code);
        accepted_items++;
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          // Open an idle burst.
          send_gap = $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          {in_kind, in_char_code} <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: take each write, compare it with the oldest prediction,
  // stall in random bursts until the quiet tail.
  // --------------------------------------------------------------------------
  int stall_left = 0;

  task automatic check_write();
    result_t want;
    if (expected_writes.size() == 0) begin
      flag_error($sformatf("write with nothing expected: addr %0d byte %02h status %0d last %0b",
                           out_write_address, out_write_byte, out_status, out_last));
    end else begin
      want = expected_writes.pop_front();
      if (out_write_address !== want.write_address)
        flag_error($sformatf("write_address %0d, expected %0d",
                             out_write_address, want.write_address));
      if (out_write_byte !== want.write_byte)
        flag_error($sformatf("write_byte %02h, expected %02h",
                             out_write_byte, want.write_byte));
      if (out_status !== want.status)
        flag_error($sformatf("status %0d, expected %0d", out_status, want.status));
      if (out_last !== want.last)
        flag_error($sformatf("last %0b, expected %0b", out_last, want.last));
      writes_checked++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall)
        check_write();
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (pending_items.size() > QUIET_TAIL && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end a hung run.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d of %0d items taken, %0d writes pending",
               cycle_count, accepted_items, total_items, expected_writes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: build all items, release reset, wait for the last write.
  // --------------------------------------------------------------------------
  initial begin
    int n_directed;

    // Directed names.
    push_item(KIND_END, 8'hFF);               // empty name, end code ignored
    push_text("AZ.az09-");                    // range ends of every class
    push_item(KIND_END, 8'h00);
    push_text("a.");                          // trailing dot
    push_item(KIND_END, 8'h41);
    push_text(".x");                          // leading dot, then dropped char
    push_item(KIND_END, 8'h2E);
    push_text("a..");                         // dot after dot
    push_item(KIND_END, 8'h80);
    push_item(KIND_CHAR, 8'h00);              // invalid at start of name
    push_item(KIND_END, 8'h7F);
    push_item(KIND_CHAR, 8'h61);
    push_item(KIND_CHAR, 8'hFF);              // invalid after a good char
    push_item(KIND_END, 8'h01);

    n_directed = pending_items.size();
    while (pending_items.size() < n_directed + RANDOM_ITEMS)
      queue_random_name();
    total_items = pending_items.size();

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_items < total_items) @(posedge clk);
    while (expected_writes.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items over %0d names: %0d stopped on an error, %0d hit the buffer limit.",
             total_items, names_seen, names_failed, names_full);
    $display("Compared %0d byte writes, %0d mismatches.", writes_checked, n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
